FILE: rtl/core/lbpc_pkg.sv
// Shared types and constants of the LED blink pattern controller.
package lbpc_pkg;

  typedef enum logic [3:0] {
    OP_TICK     = 4'd0,
    OP_SLOW     = 4'd1,
    OP_FAST     = 4'd2,
    OP_IND_ON   = 4'd3,
    OP_IND_OFF  = 4'd4,
    OP_BITS_ON  = 4'd5,
    OP_BITS_OFF = 4'd6,
    OP_CHANNELS = 4'd7,
    OP_LOAD     = 4'd8
  } lbpc_op_e;

  typedef enum logic [2:0] {
    REG_SLOW_PERIOD = 3'd0,
    REG_SLOW_BLINKS = 3'd1,
    REG_FAST_PERIOD = 3'd2,
    REG_FAST_BLINKS = 3'd3,
    REG_IND_MASK    = 3'd4,
    REG_MODE_433    = 3'd5
  } lbpc_reg_e;

  localparam logic [7:0] ChannelNibble    = 8'h0f;
  localparam logic [7:0] SlowPeriodReset  = 8'd20;
  localparam logic [7:0] SlowBlinksReset  = 8'd4;
  localparam logic [7:0] FastPeriodReset  = 8'd5;
  localparam logic [7:0] FastBlinksReset  = 8'd1;
  localparam logic [7:0] IndMaskReset     = 8'hfe;
  localparam logic [7:0] PatternReset     = 8'hff;

  // Flip the flashed (zero) bits of fm: all dark if all lit, else all lit.
  function automatic logic [7:0] flash_toggle(logic [7:0] p, logic [7:0] fm);
    logic lit;
    lit = ((p & ~fm) == 8'h00);
    return lit ? (p | ~fm) : (p & fm);
  endfunction

endpackage

FILE: rtl/core/led_blink_pattern_controller.sv
// LED blink pattern controller: command decode, flash timing and result buffer.
//
// Each request (op, mask) updates an 8-bit active-low LED pattern register
// and returns the new pattern as one result; a request is taken every cycle
// while in_ready_o is high. Results pass through an output register backed
// by a one-entry skid register, so a new request is still taken while one
// result waits; in_ready_o drops only when both hold a result.
// Configuration writes are registered and must only be issued while no
// result is outstanding.
module led_blink_pattern_controller
  import lbpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] op_i,
  input  logic [7:0] mask_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] led_pattern_o
);

  // configuration
  logic [7:0] slow_period_q, slow_blinks_q, fast_period_q, fast_blinks_q;
  logic [7:0] ind_mask_q;
  logic       mode_433_q;

  // block state
  logic [7:0] pattern_q, pattern_d;
  logic       flashing_q, flashing_d;
  logic [7:0] tick_count_q, tick_count_d;
  logic [7:0] phase_limit_q, phase_limit_d;
  logic [7:0] phase_period_q, phase_period_d;
  logic [7:0] blink_target_q, blink_target_d;
  logic [7:0] blinks_done_q, blinks_done_d;
  logic       start_locked_q, start_locked_d;
  logic       extra_toggle_q, extra_toggle_d;
  logic [7:0] flash_mask_q, flash_mask_d;

  // result buffer
  logic       out_valid_q, skid_valid_q;
  logic [7:0] out_q, skid_q;

  logic push, pop;
  assign in_ready_o    = !skid_valid_q;
  assign push          = in_valid_i && in_ready_o;
  assign pop           = out_valid_q && out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign led_pattern_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_period_q <= SlowPeriodReset;
      slow_blinks_q <= SlowBlinksReset;
      fast_period_q <= FastPeriodReset;
      fast_blinks_q <= FastBlinksReset;
      ind_mask_q    <= IndMaskReset;
      mode_433_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SLOW_PERIOD: slow_period_q <= cfg_data_i;
        REG_SLOW_BLINKS: slow_blinks_q <= cfg_data_i;
        REG_FAST_PERIOD: fast_period_q <= cfg_data_i;
        REG_FAST_BLINKS: fast_blinks_q <= cfg_data_i;
        REG_IND_MASK:    ind_mask_q    <= cfg_data_i;
        REG_MODE_433:    mode_433_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [7:0] tick_inc, done_inc, p1;
  logic       active, lit;

  always_comb begin
    pattern_d      = pattern_q;
    flashing_d     = flashing_q;
    tick_count_d   = tick_count_q;
    phase_limit_d  = phase_limit_q;
    phase_period_d = phase_period_q;
    blink_target_d = blink_target_q;
    blinks_done_d  = blinks_done_q;
    start_locked_d = start_locked_q;
    extra_toggle_d = extra_toggle_q;
    flash_mask_d   = flash_mask_q;

    active   = flashing_q && ((blinks_done_q <= blink_target_q) || (blink_target_q == 8'h00));
    tick_inc = tick_count_q + 8'd1;
    lit      = ((pattern_q & ~flash_mask_q) == 8'h00);
    done_inc = lit ? (blinks_done_q + 8'd1) : blinks_done_q;
    p1       = flash_toggle(pattern_q, flash_mask_q);

    case (op_i)
      OP_TICK: begin
        if (active) begin
          if (tick_inc < phase_limit_q) begin
            tick_count_d = tick_inc;
          end else begin
            if (lit && (blink_target_q == blinks_done_q)) start_locked_d = 1'b0;
            blinks_done_d = done_inc;
            phase_limit_d = phase_period_q;
            tick_count_d  = 8'h00;
            pattern_d     = p1;
            // closing toggle of a finished fast flash
            if ((blink_target_q < done_inc) && extra_toggle_q && mode_433_q) begin
              extra_toggle_d = 1'b0;
              pattern_d      = flash_toggle(p1, flash_mask_q);
            end
          end
        end
      end
      OP_SLOW: begin
        if (!start_locked_q) begin
          phase_limit_d  = slow_period_q;
          phase_period_d = slow_period_q;
          blink_target_d = slow_blinks_q;
          blinks_done_d  = 8'h00;
          flashing_d     = 1'b1;
          flash_mask_d   = mask_i;
          start_locked_d = 1'b1;
          extra_toggle_d = 1'b0;
        end
      end
      OP_FAST: begin
        if (!start_locked_q) begin
          phase_limit_d  = fast_period_q;
          phase_period_d = fast_period_q;
          blink_target_d = fast_blinks_q;
          blinks_done_d  = 8'h00;
          flashing_d     = 1'b1;
          flash_mask_d   = mask_i;
          extra_toggle_d = 1'b1;
        end
      end
      OP_IND_ON: begin
        flashing_d = 1'b0;
        pattern_d  = pattern_q & ind_mask_q;
      end
      OP_IND_OFF: begin
        flashing_d = 1'b0;
        pattern_d  = pattern_q | ~ind_mask_q;
      end
      OP_BITS_ON:  pattern_d = pattern_q & mask_i;
      OP_BITS_OFF: pattern_d = pattern_q | ~mask_i;
      OP_CHANNELS: pattern_d = (pattern_q | ChannelNibble) & mask_i;
      OP_LOAD:     pattern_d = mask_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q      <= PatternReset;
      flashing_q     <= 1'b0;
      tick_count_q   <= 8'h00;
      phase_limit_q  <= 8'h00;
      phase_period_q <= 8'h00;
      blink_target_q <= 8'h00;
      blinks_done_q  <= 8'h00;
      start_locked_q <= 1'b0;
      extra_toggle_q <= 1'b0;
      flash_mask_q   <= 8'h00;
    end else if (push) begin
      pattern_q      <= pattern_d;
      flashing_q     <= flashing_d;
      tick_count_q   <= tick_count_d;
      phase_limit_q  <= phase_limit_d;
      phase_period_q <= phase_period_d;
      blink_target_q <= blink_target_d;
      blinks_done_q  <= blinks_done_d;
      start_locked_q <= start_locked_d;
      extra_toggle_q <= extra_toggle_d;
      flash_mask_q   <= flash_mask_d;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push;
        end
      end else if (push) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (push && (pop || !out_valid_q)) begin
      out_q <= pattern_d;
    end
    if (push && out_valid_q && !pop) begin
      skid_q <= pattern_d;
    end
  end

endmodule
